/* rtl/trat_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trat_pkg
// Shared types and codes of the task run-time accounting table: tag and data
// words of the two slot memories, the command codes between the sequencer and
// the stores, and the control groups that pass between them.
// ----------------------------------------------------------------------------
package trat_pkg;

    localparam int ENTRIES_DEF = 1024;
    localparam int PID_W       = 32;
    localparam int TIME_W      = 64;

    // input item kinds
    localparam logic FUNC_SWITCH = 1'b0;
    localparam logic FUNC_EXIT   = 1'b1;

    // slot tag states: a tombstone keeps probe chains intact after an exit
    localparam logic [1:0] TAG_EMPTY = 2'd0;
    localparam logic [1:0] TAG_OCC   = 2'd1;
    localparam logic [1:0] TAG_TOMB  = 2'd2;

    // data store commands
    localparam logic [1:0] DOP_NONE    = 2'd0;
    localparam logic [1:0] DOP_ACCOUNT = 2'd1;
    localparam logic [1:0] DOP_STAMP   = 2'd2;
    localparam logic [1:0] DOP_INSERT  = 2'd3;

    typedef struct packed {
        logic [1:0]       st;
        logic [PID_W-1:0] key;
    } t_tag;

    // an occupied slot always holds a start stamp, so only the total has a flag
    typedef struct packed {
        logic              tp;
        logic [TIME_W-1:0] stamp;
        logic [TIME_W-1:0] total;
    } t_data;

    typedef struct packed {
        logic             start;
        logic [PID_W-1:0] key;
    } t_probe_req;

    typedef struct packed {
        logic done;
        logic hit;
        logic free_ok;
    } t_probe_rsp;

    typedef struct packed {
        logic we;
        t_tag tag;
    } t_tag_wr;

    typedef struct packed {
        logic [1:0]        op;
        logic [TIME_W-1:0] now;
    } t_data_cmd;

    typedef struct packed {
        logic              done;
        logic [TIME_W-1:0] total;
    } t_data_rsp;

endpackage

/* rtl/trat_probe.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trat_probe
// Tag memory with its clearing sweep and a linear-probe lookup engine: one
// tag read per cycle from the hashed home slot, reporting the hit slot and
// the first free slot on the probe path.
// ----------------------------------------------------------------------------
module trat_probe #(
    parameter int ENTRIES = trat_pkg::ENTRIES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  trat_pkg::t_probe_req         i_req,
    input  trat_pkg::t_tag_wr            i_twr,
    input  logic [$clog2(ENTRIES)-1:0]   i_twr_idx,
    output logic                         o_ready,
    output trat_pkg::t_probe_rsp         o_rsp,
    output logic [$clog2(ENTRIES)-1:0]   o_hit_idx,
    output logic [$clog2(ENTRIES)-1:0]   o_free_idx
);
    import trat_pkg::*;

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [AW-1:0] LAST  = AW'(ENTRIES - 1);
    localparam logic [CW-1:0] ENT_V = CW'(ENTRIES);
    localparam logic [CW-1:0] SEEN_LAST = CW'(ENTRIES - 1);

    localparam logic [1:0] P_CLEAR = 2'd0;
    localparam logic [1:0] P_IDLE  = 2'd1;
    localparam logic [1:0] P_HASH  = 2'd2;
    localparam logic [1:0] P_SCAN  = 2'd3;

    t_tag mem [ENTRIES];

    logic [1:0]       r_state, n_state;
    logic [PID_W-1:0] r_key, n_key;
    logic [AW-1:0]    r_idx, n_idx;
    logic [AW-1:0]    r_ridx;
    logic [CW-1:0]    r_issued, n_issued;
    logic [CW-1:0]    r_seen, n_seen;
    logic             r_rvld, n_rvld;
    t_tag             r_rd;
    logic             r_done, n_done;
    logic             r_hit, n_hit;
    logic             r_free_ok, n_free_ok;
    logic [AW-1:0]    r_hit_idx, n_hit_idx;
    logic [AW-1:0]    r_free_idx, n_free_idx;
    logic [AW-1:0]    r_cidx, n_cidx;

    logic [15:0]      fold;
    logic [16+CW-1:0] prod;
    logic [AW-1:0]    idx_inc;
    logic             wr_en;
    logic [AW-1:0]    wr_idx;
    t_tag             wr_data;

    // home slot: fold the key and scale it into [0, ENTRIES)
    assign fold    = r_key[31:16] ^ r_key[15:0];
    assign prod    = (16 + CW)'(fold) * (16 + CW)'(ENT_V);
    assign idx_inc = (r_idx == LAST) ? '0 : r_idx + 1'b1;

    always_comb begin
        if (r_state == P_CLEAR) begin
            wr_en   = 1'b1;
            wr_idx  = r_cidx;
            wr_data = '{st: TAG_EMPTY, key: '0};
        end else begin
            wr_en   = i_twr.we;
            wr_idx  = i_twr_idx;
            wr_data = i_twr.tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_data;
        end
        r_rd   <= mem[r_idx];
        r_ridx <= r_idx;
    end

    always_comb begin
        n_state    = r_state;
        n_key      = r_key;
        n_idx      = r_idx;
        n_issued   = r_issued;
        n_seen     = r_seen;
        n_rvld     = 1'b0;
        n_done     = 1'b0;
        n_hit      = r_hit;
        n_free_ok  = r_free_ok;
        n_hit_idx  = r_hit_idx;
        n_free_idx = r_free_idx;
        n_cidx     = r_cidx;
        case (r_state)
            P_CLEAR: begin
                n_cidx = r_cidx + 1'b1;
                if (r_cidx == LAST) begin
                    n_state = P_IDLE;
                end
            end
            P_IDLE: begin
                if (i_req.start) begin
                    n_key   = i_req.key;
                    n_state = P_HASH;
                end
            end
            P_HASH: begin
                n_idx     = prod[16 +: AW];
                n_issued  = '0;
                n_seen    = '0;
                n_hit     = 1'b0;
                n_free_ok = 1'b0;
                n_state   = P_SCAN;
            end
            P_SCAN: begin
                // issue the next read while the previous one is checked
                if (r_issued < ENT_V) begin
                    n_idx    = idx_inc;
                    n_issued = r_issued + 1'b1;
                    n_rvld   = 1'b1;
                end
                if (r_rvld) begin
                    n_seen = r_seen + 1'b1;
                    if (r_rd.st == TAG_OCC && r_rd.key == r_key) begin
                        n_hit     = 1'b1;
                        n_hit_idx = r_ridx;
                        n_done    = 1'b1;
                        n_rvld    = 1'b0;
                        n_state   = P_IDLE;
                    end else begin
                        if (r_rd.st != TAG_OCC && !r_free_ok) begin
                            n_free_ok  = 1'b1;
                            n_free_idx = r_ridx;
                        end
                        if (r_rd.st == TAG_EMPTY || r_seen == SEEN_LAST) begin
                            n_done  = 1'b1;
                            n_rvld  = 1'b0;
                            n_state = P_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = P_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= P_CLEAR;
            r_cidx  <= '0;
            r_rvld  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cidx  <= n_cidx;
            r_rvld  <= n_rvld;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key      <= n_key;
        r_idx      <= n_idx;
        r_issued   <= n_issued;
        r_seen     <= n_seen;
        r_hit      <= n_hit;
        r_free_ok  <= n_free_ok;
        r_hit_idx  <= n_hit_idx;
        r_free_idx <= n_free_idx;
    end

    assign o_ready    = (r_state == P_IDLE);
    assign o_rsp      = '{done: r_done, hit: r_hit, free_ok: r_free_ok};
    assign o_hit_idx  = r_hit_idx;
    assign o_free_idx = r_free_idx;

endmodule

/* rtl/trat_data.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trat_data
// Slot data memory (start stamp, run total and its flag) with the
// read-modify-write path that accumulates elapsed time or restamps a slot.
// ----------------------------------------------------------------------------
module trat_data #(
    parameter int ENTRIES = trat_pkg::ENTRIES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  trat_pkg::t_data_cmd          i_cmd,
    input  logic [$clog2(ENTRIES)-1:0]   i_idx,
    output trat_pkg::t_data_rsp          o_rsp
);
    import trat_pkg::*;

    localparam int AW = $clog2(ENTRIES);

    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_READ = 2'd1;
    localparam logic [1:0] D_SUM  = 2'd2;

    t_data mem [ENTRIES];

    logic [1:0]        r_state, n_state;
    logic [1:0]        r_op, n_op;
    logic [AW-1:0]     r_idx, n_idx;
    logic [TIME_W-1:0] r_now, n_now;
    t_data             r_rd;
    logic              r_tp, n_tp;
    logic [TIME_W-1:0] r_stamp, n_stamp;
    logic [TIME_W-1:0] r_tot, n_tot;
    logic [TIME_W-1:0] r_delta, n_delta;
    logic              r_done, n_done;
    logic [TIME_W-1:0] r_total, n_total;

    logic              wr_en;
    logic [AW-1:0]     wr_idx;
    t_data             wr_data;
    logic [TIME_W-1:0] sum;

    assign sum = r_tp ? r_tot + r_delta : r_delta;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_data;
        end
        r_rd <= mem[i_idx];
    end

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_idx   = r_idx;
        n_now   = r_now;
        n_tp    = r_tp;
        n_stamp = r_stamp;
        n_tot   = r_tot;
        n_delta = r_delta;
        n_done  = 1'b0;
        n_total = r_total;
        wr_en   = 1'b0;
        wr_idx  = r_idx;
        wr_data = '{tp: r_rd.tp, stamp: r_now, total: r_rd.total};
        case (r_state)
            D_IDLE: begin
                if (i_cmd.op == DOP_INSERT) begin
                    // fresh slot: stamp now, no total yet
                    wr_en   = 1'b1;
                    wr_idx  = i_idx;
                    wr_data = '{tp: 1'b0, stamp: i_cmd.now, total: '0};
                    n_done  = 1'b1;
                end else if (i_cmd.op != DOP_NONE) begin
                    n_op    = i_cmd.op;
                    n_idx   = i_idx;
                    n_now   = i_cmd.now;
                    n_state = D_READ;
                end
            end
            D_READ: begin
                if (r_op == DOP_ACCOUNT) begin
                    n_delta = r_now - r_rd.stamp;
                    n_tp    = r_rd.tp;
                    n_stamp = r_rd.stamp;
                    n_tot   = r_rd.total;
                    n_state = D_SUM;
                end else begin
                    // restamp, keep the total
                    wr_en   = 1'b1;
                    n_done  = 1'b1;
                    n_state = D_IDLE;
                end
            end
            D_SUM: begin
                wr_en   = 1'b1;
                wr_data = '{tp: 1'b1, stamp: r_stamp, total: sum};
                n_total = sum;
                n_done  = 1'b1;
                n_state = D_IDLE;
            end
            default: begin
                n_state = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_idx   <= n_idx;
        r_now   <= n_now;
        r_tp    <= n_tp;
        r_stamp <= n_stamp;
        r_tot   <= n_tot;
        r_delta <= n_delta;
        r_total <= n_total;
    end

    assign o_rsp = '{done: r_done, total: r_total};

endmodule

/* rtl/task_runtime_accounting_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// task_runtime_accounting_table
// Keyed table of tasks holding a start stamp and an accumulated run time per
// task; switch items account the outgoing task and stamp the incoming one,
// exit items remove a task.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive the item fields with start high; the item is taken
//   at the edge where start is high and busy is low. Hold start until then.
//   Result channel: o_done is high for exactly one cycle per item with the
//   result fields valid in that cycle. There is no back-pressure: capture
//   the result on that cycle or lose it.
//   Timing: each lookup walks its probe chain from the home slot, and an
//   accounting or a restamp follows it in the data store. The tag memory
//   read port, one slot per cycle, sets the pace: after many exits the
//   chains fill with tombstones and a lookup may walk all ENTRIES slots.
//   One item is in flight at a time; o_done is back in the cycle where busy
//   falls, so the next item may be taken at the edge ending the result.
//   Reset: a clearing pass writes every tag slot empty, one slot per cycle,
//   and busy stays high after reset is released until the pass is done.
// ----------------------------------------------------------------------------
module task_runtime_accounting_table #(
    parameter int ENTRIES = trat_pkg::ENTRIES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_func,
    input  logic [trat_pkg::TIME_W-1:0]   i_now_ns,
    input  logic [trat_pkg::PID_W-1:0]    i_prev_task,
    input  logic [trat_pkg::PID_W-1:0]    i_next_task,
    input  logic [trat_pkg::PID_W-1:0]    i_exit_pid,
    output logic                          o_done,
    output logic [trat_pkg::TIME_W-1:0]   o_prev_total,
    output logic                          o_prev_accounted,
    output logic                          o_table_full,
    output logic                          o_entry_removed
);
    import trat_pkg::*;

    localparam int AW = $clog2(ENTRIES);

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DISP   = 3'd1;
    localparam logic [2:0] S_PREV   = 3'd2;
    localparam logic [2:0] S_ACC    = 3'd3;
    localparam logic [2:0] S_NEXT   = 3'd4;
    localparam logic [2:0] S_STAMP  = 3'd5;
    localparam logic [2:0] S_EXIT   = 3'd6;
    localparam logic [2:0] S_RESULT = 3'd7;

    logic [2:0]        r_state, n_state;
    logic              r_func;
    logic [TIME_W-1:0] r_now;
    logic [PID_W-1:0]  r_prev, r_next, r_exit;
    logic [TIME_W-1:0] r_total, n_total;
    logic              r_acc, n_acc;
    logic              r_full, n_full;
    logic              r_rem, n_rem;
    logic              r_strobe, n_strobe;

    logic              accept;
    logic              probe_ready;
    t_probe_req        preq;
    t_probe_rsp        prsp;
    logic [AW-1:0]     hit_idx, free_idx;
    t_tag_wr           twr;
    logic [AW-1:0]     twr_idx;
    t_data_cmd         dcmd;
    logic [AW-1:0]     didx;
    t_data_rsp         drsp;

    assign busy   = (r_state != S_IDLE) || !probe_ready;
    assign accept = start && !busy;

    trat_probe #(.ENTRIES(ENTRIES)) u_probe (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (preq),
        .i_twr      (twr),
        .i_twr_idx  (twr_idx),
        .o_ready    (probe_ready),
        .o_rsp      (prsp),
        .o_hit_idx  (hit_idx),
        .o_free_idx (free_idx)
    );

    trat_data #(.ENTRIES(ENTRIES)) u_data (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (dcmd),
        .i_idx   (didx),
        .o_rsp   (drsp)
    );

    // Hold the item fields for the whole run.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func <= i_func;
            r_now  <= i_now_ns;
            r_prev <= i_prev_task;
            r_next <= i_next_task;
            r_exit <= i_exit_pid;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_total  = r_total;
        n_acc    = r_acc;
        n_full   = r_full;
        n_rem    = r_rem;
        n_strobe = 1'b0;
        preq     = '{start: 1'b0, key: r_next};
        twr      = '{we: 1'b0, tag: '{st: TAG_OCC, key: r_next}};
        twr_idx  = free_idx;
        dcmd     = '{op: DOP_NONE, now: r_now};
        didx     = hit_idx;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    // clear the result fields of the last item
                    n_total = '0;
                    n_acc   = 1'b0;
                    n_full  = 1'b0;
                    n_rem   = 1'b0;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                if (r_func == FUNC_EXIT) begin
                    preq    = '{start: 1'b1, key: r_exit};
                    n_state = S_EXIT;
                end else if (r_prev != '0) begin
                    preq    = '{start: 1'b1, key: r_prev};
                    n_state = S_PREV;
                end else if (r_next != '0) begin
                    preq    = '{start: 1'b1, key: r_next};
                    n_state = S_NEXT;
                end else begin
                    n_state = S_RESULT;
                end
            end
            S_PREV: begin
                if (prsp.done) begin
                    if (prsp.hit) begin
                        // resident outgoing task always holds a start stamp
                        dcmd    = '{op: DOP_ACCOUNT, now: r_now};
                        n_state = S_ACC;
                    end else if (r_next != '0) begin
                        preq    = '{start: 1'b1, key: r_next};
                        n_state = S_NEXT;
                    end else begin
                        n_state = S_RESULT;
                    end
                end
            end
            S_ACC: begin
                if (drsp.done) begin
                    n_total = drsp.total;
                    n_acc   = 1'b1;
                    if (r_next != '0) begin
                        preq    = '{start: 1'b1, key: r_next};
                        n_state = S_NEXT;
                    end else begin
                        n_state = S_RESULT;
                    end
                end
            end
            S_NEXT: begin
                if (prsp.done) begin
                    if (prsp.hit) begin
                        dcmd    = '{op: DOP_STAMP, now: r_now};
                        n_state = S_STAMP;
                    end else if (prsp.free_ok) begin
                        // claim the first free slot on the probe chain
                        twr     = '{we: 1'b1, tag: '{st: TAG_OCC, key: r_next}};
                        twr_idx = free_idx;
                        dcmd    = '{op: DOP_INSERT, now: r_now};
                        didx    = free_idx;
                        n_state = S_RESULT;
                    end else begin
                        n_full  = 1'b1;
                        n_state = S_RESULT;
                    end
                end
            end
            S_STAMP: begin
                if (drsp.done) begin
                    n_state = S_RESULT;
                end
            end
            S_EXIT: begin
                if (prsp.done) begin
                    if (prsp.hit) begin
                        // leave a tombstone so later chains still reach past it
                        twr     = '{we: 1'b1, tag: '{st: TAG_TOMB, key: r_exit}};
                        twr_idx = hit_idx;
                        n_rem   = 1'b1;
                    end
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                n_strobe = 1'b1;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_total <= n_total;
        r_acc   <= n_acc;
        r_full  <= n_full;
        r_rem   <= n_rem;
    end

    assign o_done           = r_strobe;
    assign o_prev_total     = r_total;
    assign o_prev_accounted = r_acc;
    assign o_table_full     = r_full;
    assign o_entry_removed  = r_rem;

endmodule

/* rtl/trat_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trat_checker
// Port-level checks of the accounting table: acceptance, result strobing
// and the consistency of the result flags.
// ----------------------------------------------------------------------------
module trat_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          o_done,
    input logic [trat_pkg::TIME_W-1:0]   o_prev_total,
    input logic                          o_prev_accounted,
    input logic                          o_table_full,
    input logic                          o_entry_removed
);
    import trat_pkg::*;

    // an accepted item keeps the block busy on the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("item accepted but block not busy");

    // a result only ever follows a busy cycle
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result without work in progress");

    // one strobe per item
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    // exit results and switch results never mix
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_entry_removed |-> !o_prev_accounted && !o_table_full)
        else $error("exit result carries switch flags");

    // no accounting means a zero total
    a_total_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_prev_accounted |-> o_prev_total == '0)
        else $error("nonzero total without accounting");

endmodule

bind task_runtime_accounting_table trat_checker u_trat_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .o_done           (o_done),
    .o_prev_total     (o_prev_total),
    .o_prev_accounted (o_prev_accounted),
    .o_table_full     (o_table_full),
    .o_entry_removed  (o_entry_removed)
);
